[rtl/rss_pkg.sv]
// ----------------------------------------------------------------------------
// Running sample statistics package
// Shared widths, defaults and the command and status structs.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int SampleBitsDefault = 16;
  localparam int CountBitsDefault  = 24;

  localparam int CountOutW  = 25;
  localparam int TotalOutW  = 40;
  localparam int SquareOutW = 55;
  localparam int MeanOutW   = 24;
  localparam int DevOutW    = 24;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // Latch the sample, update the accumulators, set up the divides.
    logic mean_dv;  // Run one step of the mean division.
    logic var_dv;   // Run one step of the variance division.
    logic sqrt_st;  // Run one step of the square root.
    logic finish;   // Capture the result registers.
  } rss_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic mean_done;
    logic var_done;
    logic sqrt_done;
  } rss_status_t;

endpackage

[rtl/running_sample_statistics.sv]
// Sequence with the default widths: a 40-step serial multiply, the 97-step
// variance division (one quotient bit a cycle) and the 32-step square root
// after it.
// Throughput: the block holds one item and takes no new sample until its
// result is taken.
// Reset: synchronous, active high; clears the count, sums, minimum and maximum.
// ----------------------------------------------------------------------------
// Running sample statistics top level
// Running count, sum, sum of squares, extremes, mean and deviation.
// ----------------------------------------------------------------------------
module running_sample_statistics
  import rss_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDefault,
  parameter int COUNT_BITS  = CountBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CountOutW-1:0]          sample_count,
  output logic signed [TotalOutW-1:0]   running_total,
  output logic [SquareOutW-1:0]         running_square_total,
  output logic signed [SAMPLE_BITS-1:0] smallest_seen,
  output logic signed [SAMPLE_BITS-1:0] largest_seen,
  output logic signed [MeanOutW-1:0]    mean_q8,
  output logic [DevOutW-1:0]            deviation_q8,
  output logic                          count_full
);

  rss_cmd_t    cmd;
  rss_status_t status;

  rss_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .status
  );

  rss_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .sample_value, .sample_count, .running_total,
    .running_square_total, .smallest_seen, .largest_seen, .mean_q8,
    .deviation_q8, .count_full
  );

endmodule

[rtl/rss_ctrl.sv]
// ----------------------------------------------------------------------------
// Running sample statistics controller
// Sequences load, divisions, square root and result handoff.
// ----------------------------------------------------------------------------
module rss_ctrl
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rss_cmd_t    cmd,
  input  rss_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SQRT = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.mean_dv = !status.mean_done;
        cmd.var_dv = !status.var_done;
        if (status.mean_done && status.var_done) state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_st = !status.sqrt_done;
        if (status.sqrt_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[rtl/rss_datapath.sv]
// ----------------------------------------------------------------------------
// Running sample statistics datapath
// Accumulators, bit-serial dividers and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module rss_datapath
  import rss_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDefault,
  parameter int COUNT_BITS  = CountBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rss_cmd_t                     cmd,
  output rss_status_t                  status,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic [CountOutW-1:0]         sample_count,
  output logic signed [TotalOutW-1:0]  running_total,
  output logic [SquareOutW-1:0]        running_square_total,
  output logic signed [SAMPLE_BITS-1:0] smallest_seen,
  output logic signed [SAMPLE_BITS-1:0] largest_seen,
  output logic signed [MeanOutW-1:0]   mean_q8,
  output logic [DevOutW-1:0]           deviation_q8,
  output logic                         count_full
);

  localparam int CW   = COUNT_BITS + 1;
  localparam int TW   = SAMPLE_BITS + COUNT_BITS;     // total width
  localparam int SQW  = 2 * SAMPLE_BITS + COUNT_BITS; // square total width
  localparam int MNW  = TW + 8;                       // mean numerator width
  localparam int DW   = 2 * CW;                       // divisor n*(n-1)
  localparam int VNW  = SQW + CW + 16;                // variance numerator width
  localparam int QW   = 64;                           // kept quotient width
  localparam int RW   = DW + 1;
  localparam int SQRT_STEPS = 32;
  localparam int MC_W = $clog2(MNW + 1);
  localparam int VC_W = $clog2(VNW + 1);
  localparam int MUL_STEPS = (TW > CW) ? TW : CW;
  localparam int ML_W = $clog2(MUL_STEPS + 1);

  logic [CW-1:0]         count_reg;
  logic signed [TW-1:0]  total_reg;
  logic [SQW-1:0]        square_total_reg;
  logic signed [SAMPLE_BITS-1:0] minimum_reg, maximum_reg;
  logic                  full_reg;

  // Mean divider state.
  logic [MNW-1:0] mnum;
  logic [CW:0]    mrem;
  logic [MC_W-1:0] mcnt;
  logic           mneg;

  // Variance divider state; the numerator shift register becomes the quotient.
  logic [VNW-1:0] vnum;
  logic [RW-1:0]  vrem;
  logic [DW-1:0]  vden;
  logic [VC_W-1:0] vcnt;
  logic           vovf;
  logic           vzero;

  // Square root state.
  logic [QW-1:0]  sx;
  logic [QW/2+1:0] srem;
  logic [QW/2-1:0] sroot;
  logic [5:0]     scnt;

  logic signed [2*SAMPLE_BITS-1:0] sq;
  logic [CW-1:0] count_next;
  logic signed [TW-1:0] total_next;
  logic [SQW-1:0] sqt_next;
  logic [TW-1:0] mag_next;
  logic [MNW-1:0] mmag;

  // The variance products and n*(n-1) are built by shift and add, one
  // multiplier bit a cycle, before the long division starts.
  logic [VNW-1:0]  prod_a, prod_b;
  logic [VNW-1:0]  adda, addb;
  logic [DW-1:0]   addd;
  logic [CW-1:0]   mula;
  logic [TW-1:0]   mulb;
  logic [ML_W-1:0] mlcnt;
  logic [TW-1:0]   vmag;
  logic            vinit;

  assign sq = sample_value * sample_value;
  assign count_next = count_reg + CW'(1);
  assign total_next = total_reg + TW'(sample_value);
  assign sqt_next = square_total_reg + SQW'($unsigned(sq));
  assign mag_next = total_next[TW-1] ? TW'(-total_next) : TW'(total_next);
  assign mmag = {mag_next, 8'd0};
  assign vmag = total_reg[TW-1] ? TW'(-total_reg) : TW'(total_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
      total_reg <= '0;
      square_total_reg <= '0;
      minimum_reg <= '0;
      maximum_reg <= '0;
    end else if (cmd.load && !count_reg[CW-1]) begin
      count_reg <= count_next;
      total_reg <= total_next;
      square_total_reg <= sqt_next;
      if (count_reg == '0) begin
        minimum_reg <= sample_value;
        maximum_reg <= sample_value;
      end else if (sample_value < minimum_reg) begin
        minimum_reg <= sample_value;
      end else if (sample_value > maximum_reg) begin
        maximum_reg <= sample_value;
      end
    end
  end

  // Mean: restoring division of |total*256| by count, one bit a cycle.
  logic [CW:0] mtrial;
  assign mtrial = {mrem[CW-1:0], mnum[MNW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      full_reg <= count_reg[CW-1];
      mcnt <= '0;
      if (count_reg[CW-1]) begin
        mnum <= {(total_reg[TW-1] ? TW'(-total_reg) : TW'(total_reg)), 8'd0};
        mneg <= total_reg[TW-1];
      end else begin
        mnum <= mmag;
        mneg <= total_next[TW-1];
      end
      mrem <= '0;
    end else if (cmd.mean_dv) begin
      if (mtrial >= {1'b0, count_reg}) begin
        mrem <= mtrial - {1'b0, count_reg};
        mnum <= {mnum[MNW-2:0], 1'b1};
      end else begin
        mrem <= mtrial;
        mnum <= {mnum[MNW-2:0], 1'b0};
      end
      mcnt <= mcnt + MC_W'(1);
    end
  end

  // Variance: serial products, then the difference, then long division.
  logic [VNW-1:0] vdiff;
  logic [RW-1:0]  vtrial;
  assign vdiff = prod_a - prod_b;
  assign vtrial = {vrem[RW-2:0], vnum[VNW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vinit <= 1'b1;
      vcnt <= '0;
      vrem <= '0;
    end else if (cmd.var_dv) begin
      if (vinit) begin
        mula <= count_reg;
        adda <= VNW'(square_total_reg);
        addd <= DW'(count_reg - CW'(1));
        mulb <= vmag;
        addb <= VNW'(vmag);
        prod_a <= '0;
        prod_b <= '0;
        vden <= '0;
        mlcnt <= '0;
        vzero <= count_reg < CW'(2);
        vinit <= 1'b0;
        vcnt <= VC_W'(1);
      end else if (vcnt == VC_W'(1)) begin
        if (mlcnt == ML_W'(MUL_STEPS)) begin
          vcnt <= VC_W'(2);
        end else begin
          if (mula[0]) begin
            prod_a <= prod_a + adda;
            vden <= vden + addd;
          end
          if (mulb[0]) prod_b <= prod_b + addb;
          mula <= mula >> 1;
          mulb <= mulb >> 1;
          adda <= adda << 1;
          addd <= addd << 1;
          addb <= addb << 1;
          mlcnt <= mlcnt + ML_W'(1);
        end
      end else if (vcnt == VC_W'(2)) begin
        vzero <= vzero || (prod_a < prod_b);
        vnum <= VNW'({vdiff[VNW-17:0], 16'd0});
        vcnt <= VC_W'(3);
      end else begin
        if (!vzero && vtrial >= {1'b0, vden}) begin
          vrem <= vtrial - {1'b0, vden};
          vnum <= {vnum[VNW-2:0], 1'b1};
        end else begin
          vrem <= vtrial;
          vnum <= {vnum[VNW-2:0], 1'b0};
        end
        vcnt <= vcnt + VC_W'(1);
      end
    end
  end

  assign status.mean_done = !cmd.load && (mcnt == MC_W'(MNW));
  assign status.var_done = !vinit && (vcnt == VC_W'(VNW + 3));

  // Square root: two radicand bits a step, restoring.
  logic [QW/2+1:0] strial;
  logic [QW/2+1:0] sdiv;
  assign strial = {srem[QW/2-1:0], sx[QW-1:QW-2]};
  assign sdiv = {sroot, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scnt <= '0;
    end else if (cmd.sqrt_st) begin
      if (scnt == '0) begin
        sx <= vnum[QW-1:0];
        vovf <= (VNW > QW) ? (|(vnum >> QW)) : 1'b0;
        srem <= '0;
        sroot <= '0;
        scnt <= 6'd1;
      end else begin
        if (strial >= sdiv) begin
          srem <= strial - sdiv;
          sroot <= {sroot[QW/2-2:0], 1'b1};
        end else begin
          srem <= strial;
          sroot <= {sroot[QW/2-2:0], 1'b0};
        end
        sx <= {sx[QW-3:0], 2'b00};
        scnt <= scnt + 6'd1;
      end
    end
  end

  assign status.sqrt_done = (scnt == 6'(SQRT_STEPS + 1));

  logic [MNW-1:0] mq;
  assign mq = mneg ? MNW'(-mnum) : mnum;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_count <= CountOutW'(count_reg);
      running_total <= TotalOutW'(total_reg);
      running_square_total <= SquareOutW'(square_total_reg);
      smallest_seen <= minimum_reg;
      largest_seen <= maximum_reg;
      mean_q8 <= MeanOutW'(mq);
      count_full <= full_reg;
      if (vzero) deviation_q8 <= '0;
      else if (vovf || (|sroot[QW/2-1:DevOutW])) deviation_q8 <= '1;
      else deviation_q8 <= sroot[DevOutW-1:0];
    end
  end

endmodule

[rtl/rss_checker.sv]
// ----------------------------------------------------------------------------
// Running sample statistics checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module rss_checker
  import rss_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CountOutW-1:0]  sample_count,
  input logic                  count_full
);

  // One item in flight: no new transfer while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A transfer in is never followed at once by a result.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result too early");

  // A result always reports at least one sample.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count != '0)
    else $error("result with zero count");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_count)
      && $stable(count_full)))
    else $error("stalled result changed");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sample_count, .count_full
);
